// ===== src/sensor_average_filter_framer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the averaging filter and telemetry framer
// Implication checks, same cycle and next cycle, with async reset disable.
// ----------------------------------------------------------------------------
`ifndef SENSOR_AVERAGE_FILTER_FRAMER_MACROS_SVH
`define SENSOR_AVERAGE_FILTER_FRAMER_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define SAFF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds -> cons holds in the next cycle
`define SAFF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/saff_pkg.sv =====
// ----------------------------------------------------------------------------
// saff_pkg
// Types, constants and the CRC byte update for the averaging filter framer.
// ----------------------------------------------------------------------------
package saff_pkg;

    localparam int MAX_BLOCK_LEN = 1024;
    localparam int FRAME_LEN     = 19;
    localparam int CRC_SPAN      = 17;
    localparam int DIV_STEPS     = 25;   // dividend width of the shared divider

    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] FRAME_MAGIC = 16'hAA55;
    localparam logic [7:0]  FRAME_VERSION = 8'd1;
    localparam logic [7:0]  FRAME_TYPE    = 8'd1;
    localparam logic [15:0] FRAME_PAYLOAD_LEN = 16'd5;
    localparam logic [7:0]  FRAME_FLAGS   = 8'd0;
    localparam logic [11:0] ADC_FULL_SCALE = 12'd4095;

    // register indexes on the configuration port
    localparam logic [1:0] REG_BLOCK_LEN    = 2'd0;
    localparam logic [1:0] REG_FILTER_SHIFT = 2'd1;
    localparam logic [1:0] REG_VREF_MV      = 2'd2;

    localparam logic [10:0] RST_BLOCK_LEN    = 11'd100;
    localparam logic [3:0]  RST_FILTER_SHIFT = 4'd3;
    localparam logic [12:0] RST_VREF_MV      = 13'd3300;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_AVG,
        ST_FILTER,
        ST_MULT,
        ST_DIV_TEMP,
        ST_SCALE,
        ST_SEND
    } state_t;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== src/sensor_average_filter_framer.sv =====
// ----------------------------------------------------------------------------
// sensor_average_filter_framer
// Block averaging, one-pole filter, temperature scaling and a 19-byte
// telemetry frame with CRC-16/CCITT-FALSE.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one item: sample and tick_ms.
//   Output channel out_valid/out_ready carries frame bytes, little-endian,
//   last_byte set on the final CRC byte.
//   Config port: cfg_we, cfg_index, cfg_data; write only while idle.
// Flow:
//   A sample that does not close a block is taken and gives no
//   output. A block-closing sample runs the shared restoring divider
//   for the average, then filter, multiply, a divide by 4095 and a
//   scale step before the first frame byte, then one byte per cycle
//   while the receiver does not stall. in_ready is low from its
//   accept until the last frame byte is taken.
// Stalls:
//   When out_ready is low the current byte holds; the frame resumes
//   once it is taken. The CRC advances only on accepted bytes.
// Reset:
//   rst_n clears the running sum and count, the filter (unseeded), the
//   sequence number, and loads the default block length, shift and vref.
// ----------------------------------------------------------------------------
`include "sensor_average_filter_framer_macros.svh"

module sensor_average_filter_framer (
    input  logic        clk,
    input  logic        rst_n,
    // input item
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] sample,
    input  logic [31:0] tick_ms,
    // result item
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        last_byte,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    saff_pkg::state_t state_reg, state_next;

    logic [10:0] block_len_reg;
    logic [3:0]  filter_shift_reg;
    logic [12:0] vref_mv_reg;

    logic [21:0] block_sum_reg, block_sum_next;
    logic [10:0] sample_count_reg, sample_count_next;
    logic [11:0] level_reg, level_next;
    logic        loaded_reg, loaded_next;
    logic [15:0] seq_reg, seq_next;

    // shared divider
    logic [24:0] dvd_reg, dvd_next;
    logic [11:0] rem_reg, rem_next;
    logic [11:0] dsr_reg, dsr_next;
    logic [4:0]  step_reg, step_next;

    logic [31:0] tick_reg, tick_next;
    logic [15:0] temp_reg, temp_next;
    logic [15:0] crc_reg, crc_next;
    logic [4:0]  idx_reg, idx_next;

    logic [10:0] len_eff;
    logic [10:0] count_inc;
    logic [21:0] sum_inc;
    logic        in_fire, out_fire, closes, div_last;
    logic [12:0] div_shift;
    logic        div_ge;
    logic [12:0] div_diff;
    logic signed [12:0] flt_diff, flt_step, flt_sum;
    logic [12:0] tq_hi;
    logic [11:0] tq_lo;
    logic [13:0] tq_sum;
    logic [1:0]  tq_adj;
    logic [12:0] tq_quot;
    logic [15:0] quot16;
    logic [7:0]  frame_bytes [saff_pkg::FRAME_LEN];

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_len_reg    <= saff_pkg::RST_BLOCK_LEN;
            filter_shift_reg <= saff_pkg::RST_FILTER_SHIFT;
            vref_mv_reg      <= saff_pkg::RST_VREF_MV;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                saff_pkg::REG_BLOCK_LEN:    block_len_reg    <= cfg_data[10:0];
                saff_pkg::REG_FILTER_SHIFT: filter_shift_reg <= cfg_data[3:0];
                saff_pkg::REG_VREF_MV:      vref_mv_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- common terms ----------------
    always_comb
    begin
        if (block_len_reg == 11'd0)
            len_eff = 11'd1;
        else if (block_len_reg > 11'(saff_pkg::MAX_BLOCK_LEN))
            len_eff = 11'(saff_pkg::MAX_BLOCK_LEN);
        else
            len_eff = block_len_reg;
    end

    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign count_inc = sample_count_reg + 11'd1;
    assign sum_inc   = block_sum_reg + {10'd0, sample};
    assign closes    = count_inc >= len_eff;
    assign div_last  = step_reg == 5'(saff_pkg::DIV_STEPS - 1);

    // one restoring step
    assign div_shift = {rem_reg, dvd_reg[24]};
    assign div_diff  = div_shift - {1'b0, dsr_reg};
    assign div_ge    = div_shift >= {1'b0, dsr_reg};

    // floor shift of the signed difference
    assign flt_diff = $signed({1'b0, dvd_reg[11:0]}) - $signed({1'b0, level_reg});
    assign flt_step = flt_diff >>> filter_shift_reg;
    assign flt_sum  = $signed({1'b0, level_reg}) + flt_step;

    // divide by 4095 = 2^12 - 1: x = hi*4095 + (hi + lo), so the quotient
    // is hi plus a correction of 0 to 3
    assign tq_hi  = dvd_reg[24:12];
    assign tq_lo  = dvd_reg[11:0];
    assign tq_sum = {1'b0, tq_hi} + {2'b00, tq_lo};

    always_comb
    begin
        if (tq_sum >= 14'(3 * saff_pkg::ADC_FULL_SCALE))
            tq_adj = 2'd3;
        else if (tq_sum >= 14'(2 * saff_pkg::ADC_FULL_SCALE))
            tq_adj = 2'd2;
        else if (tq_sum >= {2'b00, saff_pkg::ADC_FULL_SCALE})
            tq_adj = 2'd1;
        else
            tq_adj = 2'd0;
    end

    assign tq_quot = tq_hi + {11'd0, tq_adj};

    assign quot16 = {3'd0, dvd_reg[12:0]};

    // ---------------- frame bytes ----------------
    always_comb
    begin
        frame_bytes[0]  = saff_pkg::FRAME_MAGIC[7:0];
        frame_bytes[1]  = saff_pkg::FRAME_MAGIC[15:8];
        frame_bytes[2]  = saff_pkg::FRAME_VERSION;
        frame_bytes[3]  = saff_pkg::FRAME_TYPE;
        frame_bytes[4]  = saff_pkg::FRAME_PAYLOAD_LEN[7:0];
        frame_bytes[5]  = saff_pkg::FRAME_PAYLOAD_LEN[15:8];
        frame_bytes[6]  = seq_reg[7:0];
        frame_bytes[7]  = seq_reg[15:8];
        frame_bytes[8]  = tick_reg[7:0];
        frame_bytes[9]  = tick_reg[15:8];
        frame_bytes[10] = tick_reg[23:16];
        frame_bytes[11] = tick_reg[31:24];
        frame_bytes[12] = level_reg[7:0];
        frame_bytes[13] = {4'd0, level_reg[11:8]};
        frame_bytes[14] = temp_reg[7:0];
        frame_bytes[15] = temp_reg[15:8];
        frame_bytes[16] = saff_pkg::FRAME_FLAGS;
        frame_bytes[17] = crc_reg[7:0];
        frame_bytes[18] = crc_reg[15:8];
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            saff_pkg::ST_IDLE:
                if (in_fire && closes)
                    state_next = saff_pkg::ST_DIV_AVG;
            saff_pkg::ST_DIV_AVG:
                if (div_last)
                    state_next = saff_pkg::ST_FILTER;
            saff_pkg::ST_FILTER:
                state_next = saff_pkg::ST_MULT;
            saff_pkg::ST_MULT:
                state_next = saff_pkg::ST_DIV_TEMP;
            saff_pkg::ST_DIV_TEMP:
                state_next = saff_pkg::ST_SCALE;
            saff_pkg::ST_SCALE:
                state_next = saff_pkg::ST_SEND;
            saff_pkg::ST_SEND:
                if (out_fire && last_byte)
                    state_next = saff_pkg::ST_IDLE;
            default:
                state_next = saff_pkg::ST_IDLE;
        endcase
    end

    // ---------------- outputs ----------------
    always_comb
    begin
        in_ready   = state_reg == saff_pkg::ST_IDLE;
        out_valid  = state_reg == saff_pkg::ST_SEND;
        frame_byte = frame_bytes[idx_reg];
        last_byte  = idx_reg == 5'(saff_pkg::FRAME_LEN - 1);
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        block_sum_next    = block_sum_reg;
        sample_count_next = sample_count_reg;
        level_next        = level_reg;
        loaded_next       = loaded_reg;
        seq_next          = seq_reg;
        dvd_next          = dvd_reg;
        rem_next          = rem_reg;
        dsr_next          = dsr_reg;
        step_next         = step_reg;
        tick_next         = tick_reg;
        temp_next         = temp_reg;
        crc_next          = crc_reg;
        idx_next          = idx_reg;

        case (state_reg)
            saff_pkg::ST_IDLE:
                if (in_fire)
                begin
                    if (closes)
                    begin
                        block_sum_next    = '0;
                        sample_count_next = '0;
                        dvd_next          = {3'd0, sum_inc};
                        dsr_next          = {1'b0, count_inc};
                        rem_next          = '0;
                        step_next         = '0;
                        tick_next         = tick_ms;
                    end
                    else
                    begin
                        block_sum_next    = sum_inc;
                        sample_count_next = count_inc;
                    end
                end
            saff_pkg::ST_DIV_AVG:
            begin
                rem_next  = div_ge ? div_diff[11:0] : div_shift[11:0];
                dvd_next  = {dvd_reg[23:0], div_ge};
                step_next = step_reg + 5'd1;
            end
            saff_pkg::ST_FILTER:
            begin
                // quotient of the average division sits in dvd_reg
                loaded_next = 1'b1;
                if (loaded_reg)
                    level_next = flt_sum[11:0];
                else
                    level_next = dvd_reg[11:0];
            end
            saff_pkg::ST_MULT:
                dvd_next = {13'd0, level_reg} * {12'd0, vref_mv_reg};
            saff_pkg::ST_DIV_TEMP:
                dvd_next = {12'd0, tq_quot};
            saff_pkg::ST_SCALE:
            begin
                temp_next = (quot16 << 3) + (quot16 << 1);
                crc_next  = saff_pkg::CRC_INIT;
                idx_next  = '0;
            end
            saff_pkg::ST_SEND:
                if (out_fire)
                begin
                    if (idx_reg < 5'(saff_pkg::CRC_SPAN))
                        crc_next = saff_pkg::crc_byte(crc_reg, frame_byte);
                    if (last_byte)
                        seq_next = seq_reg + 16'd1;
                    else
                        idx_next = idx_reg + 5'd1;
                end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= saff_pkg::ST_IDLE;
            block_sum_reg    <= '0;
            sample_count_reg <= '0;
            level_reg        <= '0;
            loaded_reg       <= 1'b0;
            seq_reg          <= '0;
            step_reg         <= '0;
            idx_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            block_sum_reg    <= block_sum_next;
            sample_count_reg <= sample_count_next;
            level_reg        <= level_next;
            loaded_reg       <= loaded_next;
            seq_reg          <= seq_next;
            step_reg         <= step_next;
            idx_reg          <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        tick_reg <= tick_next;
        temp_reg <= temp_next;
        crc_reg  <= crc_next;
    end

    // ---------------- assertions ----------------
    `SAFF_ASSERT_SAME(a_div_rem_bound, clk, rst_n,
        (state_reg == saff_pkg::ST_DIV_AVG),
        (rem_reg < dsr_reg), "divider remainder not below divisor")
    `SAFF_ASSERT_SAME(a_frame_after_seed, clk, rst_n,
        out_valid, loaded_reg, "frame sent before filter was seeded")
    `SAFF_ASSERT_NEXT(a_idle_after_frame, clk, rst_n,
        (out_fire && last_byte), (in_ready && sample_count_reg == 11'd0),
        "block not idle and cleared after frame end")

endmodule
